/* design/pwtx_pkg.sv */
package pwtx_pkg;

    localparam int FRAME_BITS_DEF = 7;

    localparam int OP_W   = 2;
    localparam int MODE_W = 3;
    localparam int PER_W  = 8;
    localparam int WORD_W = MODE_W + PER_W;
    localparam int DIR_POS = 6;

    localparam int TICK_W = 8;
    localparam int LEAD_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD  = 2'd3;

    localparam logic [TICK_W-1:0] SHORT_RST = 8'd4;
    localparam logic [TICK_W-1:0] LONG_RST  = 8'd8;
    localparam logic [TICK_W-1:0] STOP_RST  = 8'd16;
    localparam logic [LEAD_W-1:0] LEAD_RST  = 10'd40;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [MODE_W-1:0] motor_mode;
        logic [PER_W-1:0]  motor_period;
        logic              motor_dir;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_result;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] stop_ticks;
        logic [LEAD_W-1:0] lead_ticks;
    } t_cfg;

endpackage

/* design/pwtx_in_stage.sv */
module pwtx_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pwtx_pkg::t_item i_item,
    output logic           o_valid,
    output pwtx_pkg::t_item o_item,
    input  logic           i_take
);
    import pwtx_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* design/pwtx_frame_fsm.sv */
module pwtx_frame_fsm #(
    parameter int FRAME_BITS = pwtx_pkg::FRAME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwtx_pkg::t_cfg   i_cfg,
    input  pwtx_pkg::t_item  i_item,
    input  logic             i_adv,
    output pwtx_pkg::t_result o_result
);
    import pwtx_pkg::*;

    localparam int BIT_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam int EXT_W = WORD_W + FRAME_BITS;
    localparam int CNT_W = TICK_W + 1;
    localparam int LCNT_W = LEAD_W + 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_BITS - 1);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_BITS  = 2'd1,
        PH_STOP  = 2'd2
    } t_phase;

    logic                  r_sending, n_sending;
    t_phase                r_phase, n_phase;
    logic                  r_high_half, n_high_half;
    logic [CNT_W-1:0]      r_pulse_count, n_pulse_count;
    logic [LCNT_W-1:0]     r_lead_count, n_lead_count;
    logic [BIT_W-1:0]      r_bit_index, n_bit_index;
    logic [FRAME_BITS-1:0] r_frame_word, n_frame_word;
    logic                  r_level, n_level;
    logic                  done;

    logic [CNT_W-1:0]  cnt_inc;
    logic [WORD_W-1:0] word;
    logic [EXT_W-1:0]  word_ext;
    logic              cur_bit;
    logic [TICK_W-1:0] high_len;
    logic [TICK_W-1:0] short_min, high_min, long_min, stop_min;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] t);
        return (t == '0) ? TICK_W'(1) : t;
    endfunction

    assign cnt_inc  = r_pulse_count + CNT_W'(1);
    assign word     = {i_item.motor_period, i_item.motor_mode}
                    | (WORD_W'(i_item.motor_dir) << DIR_POS);
    assign word_ext = EXT_W'(word);
    assign cur_bit  = r_frame_word[r_bit_index];
    assign high_len = cur_bit ? i_cfg.long_ticks : i_cfg.short_ticks;
    assign short_min = at_least_one(i_cfg.short_ticks);
    assign long_min  = at_least_one(i_cfg.long_ticks);
    assign stop_min  = at_least_one(i_cfg.stop_ticks);
    assign high_min  = at_least_one(high_len);

    always_comb begin
        n_sending     = r_sending;
        n_phase       = r_phase;
        n_high_half   = r_high_half;
        n_pulse_count = r_pulse_count;
        n_lead_count  = r_lead_count;
        n_bit_index   = r_bit_index;
        n_frame_word  = r_frame_word;
        n_level       = r_level;
        done          = 1'b0;

        unique case (i_item.operation)
            OP_TICK: begin
                if (!r_sending) begin
                    n_phase       = PH_START;
                    n_high_half   = 1'b0;
                    n_pulse_count = '0;
                    n_lead_count  = '0;
                    n_bit_index   = '0;
                    n_level       = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_START: begin
                            if (r_lead_count <= LCNT_W'(i_cfg.lead_ticks)) begin
                                n_lead_count = r_lead_count + LCNT_W'(1);
                            end else if (!r_high_half) begin
                                n_level       = 1'b0;
                                n_pulse_count = cnt_inc;
                                if (cnt_inc > CNT_W'(i_cfg.long_ticks)) begin
                                    n_level       = 1'b1;
                                    n_high_half   = 1'b1;
                                    n_pulse_count = '0;
                                end
                            end else begin
                                n_pulse_count = cnt_inc;
                                if (cnt_inc >= CNT_W'(long_min)) begin
                                    n_level       = 1'b0;
                                    n_high_half   = 1'b0;
                                    n_phase       = PH_BITS;
                                    n_pulse_count = '0;
                                end
                            end
                        end
                        PH_BITS: begin
                            n_pulse_count = cnt_inc;
                            if (!r_high_half) begin
                                if (cnt_inc >= CNT_W'(short_min)) begin
                                    n_level       = 1'b1;
                                    n_high_half   = 1'b1;
                                    n_pulse_count = '0;
                                end
                            end else if (cnt_inc >= CNT_W'(high_min)) begin
                                n_level       = 1'b0;
                                n_high_half   = 1'b0;
                                n_pulse_count = '0;
                                if (r_bit_index == LAST_BIT) begin
                                    n_bit_index = '0;
                                    n_phase     = PH_STOP;
                                end else begin
                                    n_bit_index = r_bit_index + BIT_W'(1);
                                end
                            end
                        end
                        default: begin
                            // stop pulse, unused phase code included
                            n_level       = 1'b0;
                            n_pulse_count = cnt_inc;
                            if (cnt_inc >= CNT_W'(stop_min)) begin
                                n_level       = 1'b1;
                                n_pulse_count = '0;
                                n_phase       = PH_START;
                                n_bit_index   = '0;
                                n_sending     = 1'b0;
                                done          = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_START: begin
                n_frame_word  = word_ext[FRAME_BITS-1:0];
                n_phase       = PH_START;
                n_high_half   = 1'b0;
                n_pulse_count = '0;
                n_lead_count  = '0;
                n_bit_index   = '0;
                n_sending     = 1'b1;
                n_level       = 1'b1;
            end
            OP_STOP: begin
                n_phase       = PH_START;
                n_high_half   = 1'b0;
                n_pulse_count = '0;
                n_lead_count  = '0;
                n_bit_index   = '0;
                n_sending     = 1'b0;
                n_level       = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_result.line_level = n_level;
    assign o_result.busy_res   = n_sending;
    assign o_result.frame_done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending     <= 1'b0;
            r_phase       <= PH_START;
            r_high_half   <= 1'b0;
            r_pulse_count <= '0;
            r_lead_count  <= '0;
            r_bit_index   <= '0;
            r_frame_word  <= '0;
            r_level       <= 1'b1;
        end else if (i_adv) begin
            r_sending     <= n_sending;
            r_phase       <= n_phase;
            r_high_half   <= n_high_half;
            r_pulse_count <= n_pulse_count;
            r_lead_count  <= n_lead_count;
            r_bit_index   <= n_bit_index;
            r_frame_word  <= n_frame_word;
            r_level       <= n_level;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && done) |-> (!n_sending && n_level))
        else $error("frame done while still busy or line low");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_phase == PH_START && !r_high_half))
        else $error("idle with frame progress left");

    a_high_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_half |-> (r_sending && r_phase != PH_STOP))
        else $error("high half outside start or bit phase");

    a_bit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_index != '0) |-> (r_phase == PH_BITS))
        else $error("bit index left over outside bit phase");

endmodule

/* design/pwtx_out_stage.sv */
module pwtx_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pwtx_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output pwtx_pkg::t_result o_result
);
    import pwtx_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* design/pulse_width_one_wire_transmitter_core.sv */
// Pulse-width single-wire frame transmitter. Each request is one timer tick, a start
// (load mode, period and direction into the frame word and arm the sender) or a stop,
// and each request gives exactly one result: the wire level after it, the busy flag and
// a done pulse on the tick that ends the stop pulse. A request is taken every clock
// cycle unless back-pressure holds the result register; its result passes the input
// register and the result register around the state update. The user must write the
// tick lengths over the configuration port only while no request is in flight; the
// block does not enforce it. The port is always ready; no clearing pass after reset.
module pulse_width_one_wire_transmitter_core #(
    parameter int FRAME_BITS = pwtx_pkg::FRAME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pwtx_pkg::OP_W-1:0]          i_operation,
    input  logic [pwtx_pkg::MODE_W-1:0]        i_motor_mode,
    input  logic [pwtx_pkg::PER_W-1:0]         i_motor_period,
    input  logic                               i_motor_dir,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_line_level,
    output logic                               o_busy_res,
    output logic                               o_frame_done,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pwtx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pwtx_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pwtx_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   s1_item;
    t_result fsm_result;
    t_result out_result;
    logic    s1_valid;
    logic    can_load;
    logic    adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_ticks <= SHORT_RST;
            r_cfg.long_ticks  <= LONG_RST;
            r_cfg.stop_ticks  <= STOP_RST;
            r_cfg.lead_ticks  <= LEAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SHORT: r_cfg.short_ticks <= i_cfg_wdata[TICK_W-1:0];
                REG_LONG:  r_cfg.long_ticks  <= i_cfg_wdata[TICK_W-1:0];
                REG_STOP:  r_cfg.stop_ticks  <= i_cfg_wdata[TICK_W-1:0];
                REG_LEAD:  r_cfg.lead_ticks  <= i_cfg_wdata[LEAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_item.operation    = i_operation;
    assign in_item.motor_mode   = i_motor_mode;
    assign in_item.motor_period = i_motor_period;
    assign in_item.motor_dir    = i_motor_dir;

    assign adv = s1_valid && can_load;

    pwtx_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (s1_valid),
        .o_item  (s1_item),
        .i_take  (adv)
    );

    pwtx_frame_fsm #(
        .FRAME_BITS (FRAME_BITS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (s1_item),
        .i_adv    (adv),
        .o_result (fsm_result)
    );

    pwtx_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_result   (fsm_result),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_line_level = out_result.line_level;
    assign o_busy_res   = out_result.busy_res;
    assign o_frame_done = out_result.frame_done;

endmodule
